[rtl/what_pkg.sv]
`timescale 1ns / 1ps
// Shared types and constants of the windowed hit alarm trigger.
// No dependencies; used by what_ram's users and the top level.
package what_pkg;

	// Sizing of the per-class hit FIFOs.
	localparam int MAX_HITS    = 64;
	localparam int NUM_CLASSES = 2;
	localparam int CLS_W       = 1;
	localparam int HEAD_W      = $clog2(MAX_HITS);
	localparam int CNT_W       = $clog2(MAX_HITS + 1);
	localparam int STORE_DEPTH = NUM_CLASSES << HEAD_W;
	localparam int STORE_AW    = CLS_W + HEAD_W;

	// Field widths.
	localparam int TIME_W   = 32;
	localparam int WIN_W    = 20;
	localparam int THR_W    = 7;
	localparam int HITS_W   = 7;
	localparam int HITS_MAX = (1 << HITS_W) - 1;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_WINDOW    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_COOLDOWN  = 2'd2;

	// Reset values of the configuration registers.
	localparam logic [WIN_W-1:0] WINDOW_RST   = 20'd5000;
	localparam logic [THR_W-1:0] THR_RST      = 7'd3;
	localparam logic [WIN_W-1:0] COOLDOWN_RST = 20'd15000;

	typedef logic [HEAD_W-1:0] head_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	// Next position in a ring of MAX_HITS entries.
	function automatic head_t ring_next(input head_t pos);
		logic [HEAD_W:0] s;
		s = {1'b0, pos} + 1'b1;
		if (s >= (HEAD_W+1)'(MAX_HITS)) begin
			s = '0;
		end
		return s[HEAD_W-1:0];
	endfunction

	// Ring position pos + off, with off below MAX_HITS.
	function automatic head_t ring_add(input head_t pos, input cnt_t off);
		logic [CNT_W:0] s;
		s = (CNT_W+1)'(pos) + (CNT_W+1)'(off);
		if (s >= (CNT_W+1)'(MAX_HITS)) begin
			s = s - (CNT_W+1)'(MAX_HITS);
		end
		return s[HEAD_W-1:0];
	endfunction

endpackage

[rtl/what_ram.sv]
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package needed.
module what_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

[rtl/windowed_hit_alarm_trigger.sv]
`timescale 1ns / 1ps
// Windowed hit alarm trigger: per-class sliding-window hit counter with cooldown.
// Depends on what_pkg and the hit time store what_ram.
//
// Usage:
//   Reports enter on the s_ stream: s_tuser carries the violation flag and the
//   event class, s_tdata the 32-bit timestamp. Each report yields exactly one
//   result on the m_ stream: alarm flag, hit count, dropped flag in m_tdata and
//   the class in m_tuser. Registers are written over the cfg_ channel, which
//   is always ready; write them only while the block is idle.
//   Sequence: a report without a violation goes from transfer straight to
//   finish; a violation goes through append, then prune and check until the
//   oldest hit is unexpired or none is left. Each pop needs one hit time store
//   read and one pass through the shared subtract and compare unit. s_tready is
//   high only while the sequencer is idle, so one report is in work at a time.
//   The result sits in an output register, so the next report can be taken
//   while a result still waits; when the receiver stalls with a result pending,
//   the sequencer holds its finished item until the register frees up.
//   Reset clears FIFO heads, counts, alarm history and restores the register
//   defaults; the hit time store needs no clearing pass.
module windowed_hit_alarm_trigger (
	input  logic                           clk,
	input  logic                           arst_n,
	// Report stream.
	input  logic                           s_tvalid,
	output logic                           s_tready,
	input  logic [31:0]                    s_tdata,  // [31:0] timestamp
	input  logic [1:0]                     s_tuser,  // [0] violation, [1] event_class
	// Result stream.
	output logic                           m_tvalid,
	input  logic                           m_tready,
	output logic [15:0]                    m_tdata,  // [0] alarm, [7:1] hits_in_window,
	                                                 // [8] dropped_oldest, rest zero
	output logic                           m_tuser,  // [0] alarm_class
	// Configuration writes.
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [what_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]                    cfg_data
);
	import what_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_APPEND = 3'd1;
	localparam logic [2:0] ST_PRUNE  = 3'd2;
	localparam logic [2:0] ST_CHECK  = 3'd3;
	localparam logic [2:0] ST_FINISH = 3'd4;

	logic [2:0] state_q;

	// Configuration registers.
	logic [WIN_W-1:0] window_q;
	logic [THR_W-1:0] threshold_q;
	logic [WIN_W-1:0] cooldown_q;

	// Per-class FIFO control and alarm history.
	head_t             fifo_head_q [NUM_CLASSES];
	cnt_t              fifo_count_q [NUM_CLASSES];
	logic [TIME_W-1:0] last_alarm_q [NUM_CLASSES];
	logic              fired_q [NUM_CLASSES];

	// Item under work.
	logic              viol_q;
	logic [CLS_W-1:0]  cls_q;
	logic [TIME_W-1:0] now_q;
	head_t             work_head_q;
	cnt_t              work_cnt_q;
	logic              dropped_q;

	// Output register.
	logic              m_valid_q;
	logic              out_alarm_q;
	logic [HITS_W-1:0] out_hits_q;
	logic              out_cls_q;
	logic              out_dropped_q;

	// Store ports.
	logic                store_we;
	logic [STORE_AW-1:0] store_waddr;
	logic [STORE_AW-1:0] store_raddr;
	logic [TIME_W-1:0]   store_rdata;

	// Shared subtract/compare unit and helpers.
	logic [TIME_W-1:0] sub_b;
	logic [TIME_W-1:0] diff;
	logic              expired;
	logic              in_cooldown;
	logic              alarm;
	logic [THR_W-1:0]  thr_eff;
	logic [HITS_W-1:0] hits_sat;
	logic              accept;
	logic              out_free;
	logic              cls_ok;
	head_t             append_head;
	cnt_t              append_cnt;
	logic              append_drop;

	assign s_tready  = (state_q == ST_IDLE);
	assign accept    = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;
	assign out_free  = !m_valid_q || m_tready;
	assign cls_ok    = int'(s_tuser[1]) < NUM_CLASSES;

	assign m_tvalid = m_valid_q;
	assign m_tdata  = {7'd0, out_dropped_q, out_hits_q, out_alarm_q};
	assign m_tuser  = out_cls_q;

	// One subtractor serves the window test and the cooldown test.
	assign sub_b       = (state_q == ST_CHECK) ? store_rdata : last_alarm_q[cls_q];
	assign diff        = now_q - sub_b;
	assign expired     = diff > TIME_W'(window_q);
	assign in_cooldown = fired_q[cls_q] && (diff < TIME_W'(cooldown_q));

	// Threshold of zero acts as one; above MAX_HITS it can never be reached.
	assign thr_eff  = (threshold_q == '0) ? THR_W'(1) : threshold_q;
	assign alarm    = viol_q && (int'(work_cnt_q) >= int'(thr_eff)) && !in_cooldown;
	assign hits_sat = (int'(work_cnt_q) > HITS_MAX) ? HITS_W'(HITS_MAX)
	                                                : HITS_W'(work_cnt_q);

	// A full FIFO gives up its oldest hit before the append.
	always_comb begin
		if (int'(work_cnt_q) >= MAX_HITS) begin
			append_head = ring_next(work_head_q);
			append_cnt  = CNT_W'(MAX_HITS - 1);
			append_drop = 1'b1;
		end else begin
			append_head = work_head_q;
			append_cnt  = work_cnt_q;
			append_drop = 1'b0;
		end
	end

	assign store_we    = (state_q == ST_APPEND);
	assign store_waddr = {cls_q, ring_add(append_head, append_cnt)};
	assign store_raddr = {cls_q, work_head_q};

	what_ram #(
		.WIDTH (TIME_W),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (store_we),
		.waddr (store_waddr),
		.wdata (now_q),
		.raddr (store_raddr),
		.rdata (store_rdata)
	);

	// Configuration register writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q    <= WINDOW_RST;
			threshold_q <= THR_RST;
			cooldown_q  <= COOLDOWN_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				CFG_WINDOW:    window_q    <= cfg_data[WIN_W-1:0];
				CFG_THRESHOLD: threshold_q <= cfg_data[THR_W-1:0];
				CFG_COOLDOWN:  cooldown_q  <= cfg_data[WIN_W-1:0];
				default: ;
			endcase
		end
	end

	// Sequencer, per-class state and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			m_valid_q <= 1'b0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				fifo_head_q[c]  <= '0;
				fifo_count_q[c] <= '0;
				last_alarm_q[c] <= '0;
				fired_q[c]      <= 1'b0;
			end
		end else begin
			// The output register refills when an item finishes and empties on a transfer.
			if (state_q == ST_FINISH && out_free) begin
				m_valid_q <= 1'b1;
			end else if (m_tready) begin
				m_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (s_tuser[0] && cls_ok) ? ST_APPEND : ST_FINISH;
					end
				end
				ST_APPEND: begin
					state_q <= ST_PRUNE;
				end
				ST_PRUNE: begin
					state_q <= (work_cnt_q == '0) ? ST_FINISH : ST_CHECK;
				end
				ST_CHECK: begin
					state_q <= expired ? ST_PRUNE : ST_FINISH;
				end
				ST_FINISH: begin
					if (out_free) begin
						state_q <= ST_IDLE;
						if (viol_q) begin
							if (alarm) begin
								fifo_head_q[cls_q]  <= '0;
								fifo_count_q[cls_q] <= '0;
								last_alarm_q[cls_q] <= now_q;
								fired_q[cls_q]      <= 1'b1;
							end else begin
								fifo_head_q[cls_q]  <= work_head_q;
								fifo_count_q[cls_q] <= work_cnt_q;
							end
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Working copy of the item and its class FIFO; payload only.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					viol_q      <= s_tuser[0] && cls_ok;
					cls_q       <= s_tuser[1];
					now_q       <= s_tdata;
					dropped_q   <= 1'b0;
					work_head_q <= fifo_head_q[s_tuser[1]];
					work_cnt_q  <= fifo_count_q[s_tuser[1]];
				end
			end
			ST_APPEND: begin
				work_head_q <= append_head;
				work_cnt_q  <= append_cnt + 1'b1;
				dropped_q   <= append_drop;
			end
			ST_CHECK: begin
				if (expired) begin
					work_head_q <= ring_next(work_head_q);
					work_cnt_q  <= work_cnt_q - 1'b1;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					out_alarm_q   <= alarm;
					out_hits_q    <= viol_q ? hits_sat : '0;
					out_cls_q     <= cls_q;
					out_dropped_q <= viol_q && dropped_q;
				end
			end
			default: ;
		endcase
	end

endmodule

[sim/windowed_hit_alarm_trigger_test.sv]
`timescale 1ns / 1ps
// Self-checking testbench for windowed_hit_alarm_trigger: streams timestamped reports,
// rewrites the window, threshold and cooldown registers between phases and checks each result.
// Depends on what_pkg and the windowed_hit_alarm_trigger RTL.
module windowed_hit_alarm_trigger_test;
	import what_pkg::*;

	localparam int unsigned CYCLE_LIMIT   = 1_500_000;
	localparam int unsigned PHASE_COUNT   = 10;
	localparam int unsigned HITS_PER_RUN  = 175;
	localparam int unsigned HOLD_AT       = 1300;
	localparam int unsigned HOLD_CYCLES   = 300;

	// One expected result: alarm flag, hit count, class and dropped flag.
	typedef struct packed {
		logic              alarm;
		logic [HITS_W-1:0] hits;
		logic              cls;
		logic              dropped;
	} alarm_result_t;

	// Per-class hit FIFOs with cooldown, and the queue of results still owed.
	class alarm_scoreboard;
		logic [TIME_W-1:0] stamp_ring   [NUM_CLASSES][MAX_HITS];
		int unsigned       oldest       [NUM_CLASSES];
		int unsigned       held         [NUM_CLASSES];
		logic [TIME_W-1:0] last_trigger [NUM_CLASSES];
		bit                triggered    [NUM_CLASSES];
		logic [WIN_W-1:0]  window_len;
		logic [THR_W-1:0]  threshold;
		logic [WIN_W-1:0]  quiet_len;
		alarm_result_t     owed_q [$];
		int unsigned       failures;

		function new();
			window_len = WINDOW_RST;
			threshold  = THR_RST;
			quiet_len  = COOLDOWN_RST;
			failures   = 0;
			for (int c = 0; c < NUM_CLASSES; c++) begin
				oldest[c]       = 0;
				held[c]         = 0;
				last_trigger[c] = '0;
				triggered[c]    = 1'b0;
			end
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] value);
			case (idx)
				CFG_WINDOW:    window_len = value[WIN_W-1:0];
				CFG_THRESHOLD: threshold  = value[THR_W-1:0];
				CFG_COOLDOWN:  quiet_len  = value[WIN_W-1:0];
				default: ;
			endcase
		endfunction

		// Update the class state for one accepted report and queue its result.
		function void note_report(logic violation, logic [CLS_W-1:0] cls, logic [TIME_W-1:0] stamp);
			alarm_result_t     res;
			int unsigned       c;
			int unsigned       need;
			logic [TIME_W-1:0] age;
			res     = '0;
			res.cls = cls;
			c       = cls;
			if (violation && c < NUM_CLASSES) begin
				// A full FIFO gives up its oldest hit to make room.
				if (held[c] >= MAX_HITS) begin
					oldest[c]   = (oldest[c] + 1) % MAX_HITS;
					held[c]     = MAX_HITS - 1;
					res.dropped = 1'b1;
				end
				stamp_ring[c][(oldest[c] + held[c]) % MAX_HITS] = stamp;
				held[c]++;
				// Retire hits older than the window; the fresh hit always stays.
				while (held[c] > 0) begin
					age = stamp - stamp_ring[c][oldest[c]];
					if (age <= window_len) break;
					oldest[c] = (oldest[c] + 1) % MAX_HITS;
					held[c]--;
				end
				res.hits = (held[c] > HITS_MAX) ? HITS_W'(HITS_MAX) : HITS_W'(held[c]);
				// A zero threshold behaves like one; the cooldown only binds after a first alarm.
				need = (threshold == 0) ? 1 : threshold;
				age  = stamp - last_trigger[c];
				if (held[c] >= need && !(triggered[c] && age < quiet_len)) begin
					res.alarm       = 1'b1;
					last_trigger[c] = stamp;
					triggered[c]    = 1'b1;
					held[c]         = 0;
					oldest[c]       = 0;
				end
			end
			owed_q.insert(owed_q.size(), res);
		endfunction

		function void compare_field(string name, logic [15:0] want, logic [15:0] got);
			if (got !== want) begin
				$error("%s: expected %0d, got %0d", name, want, got);
				failures++;
			end
		endfunction

		// Match one result transfer against the oldest owed result.
		function void check_result(logic [15:0] data, logic user);
			alarm_result_t want;
			if (owed_q.size() == 0) begin
				$error("result transfer with no report outstanding: m_tdata=%h m_tuser=%b",
					data, user);
				failures++;
				return;
			end
			want = owed_q[0];
			owed_q.delete(0);
			compare_field("alarm", 16'(want.alarm), 16'(data[0]));
			compare_field("hits_in_window", 16'(want.hits), 16'(data[7:1]));
			compare_field("dropped_oldest", 16'(want.dropped), 16'(data[8]));
			compare_field("m_tdata padding", 16'd0, 16'(data[15:9]));
			compare_field("alarm_class", 16'(want.cls), 16'(user));
		endfunction

		function int unsigned pending();
			return owed_q.size();
		endfunction
	endclass

	logic                 clk       = 1'b0;
	logic                 arst_n    = 1'b0;
	logic                 s_tvalid  = 1'b0;
	logic                 s_tready;
	logic [31:0]          s_tdata   = '0;
	logic [1:0]           s_tuser   = '0;
	logic                 m_tvalid;
	logic                 m_tready  = 1'b0;
	logic [15:0]          m_tdata;
	logic                 m_tuser;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = CFG_WINDOW;
	logic [31:0]          cfg_data  = '0;

	int unsigned     src_idle_pct  = 14;
	int unsigned     sink_idle_pct = 61;
	int unsigned     results_seen  = 0;
	int unsigned     total_hits    = 0;
	bit              held_off      = 1'b0;
	alarm_scoreboard board         = new();

	windowed_hit_alarm_trigger DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Offer one report, with a random gap first, and wait for its transfer.
	task automatic send_report(input logic violation, input logic cls, input logic [31:0] stamp);
		if ($urandom_range(99) < src_idle_pct) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= stamp;
		s_tuser  <= {cls, violation};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_report(violation, cls, stamp);
	endtask

	// Stop offering and wait until every owed result has come out.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (board.pending() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write all three registers back to back; noisy fills the unused upper bits.
	task automatic load_settings(input logic [31:0] window_val, input logic [31:0] thr_val,
			input logic [31:0] cool_val, input bit noisy);
		logic [31:0]          vals [3];
		logic [CFG_IDX_W-1:0] regs [3];
		logic [31:0]          word;
		vals = '{window_val, thr_val, cool_val};
		regs = '{CFG_WINDOW, CFG_THRESHOLD, CFG_COOLDOWN};
		for (int i = 0; i < 3; i++) begin
			word = vals[i];
			if (noisy) begin
				if (regs[i] == CFG_THRESHOLD) word[31:THR_W] = (32 - THR_W)'($urandom());
				else word[31:WIN_W] = (32 - WIN_W)'($urandom());
			end
			cfg_valid <= 1'b1;
			cfg_index <= regs[i];
			cfg_data  <= word;
			@(posedge clk);
			while (!cfg_ready) @(posedge clk);
			board.write_reg(regs[i], word);
		end
		cfg_valid <= 1'b0;
	endtask

	// Mostly rising timestamps paced to the window and threshold, with stray reports mixed in.
	task automatic run_phase(input int unsigned win, input int unsigned thr,
			input int unsigned cool, input bit dense);
		logic [31:0] now;
		int unsigned thr_eff;
		int unsigned span;
		int unsigned gap;
		int unsigned sent;
		int unsigned roll;
		now = $urandom();
		if ($urandom_range(3) == 0) begin
			now = 32'hFFFF_FFFF - $urandom_range(0, 4 * win);
		end
		thr_eff = (thr == 0) ? 1 : ((thr > MAX_HITS) ? MAX_HITS : thr);
		span    = dense ? win / (4 * thr_eff) + 1 : win / thr_eff + 1;
		sent    = 0;
		while (sent < HITS_PER_RUN) begin
			if (total_hits < 583) begin
				src_idle_pct  = 14;
				sink_idle_pct = 61;
			end else if (total_hits < 1166) begin
				src_idle_pct  = 61;
				sink_idle_pct = 14;
			end else begin
				src_idle_pct  = 0;
				sink_idle_pct = 0;
			end
			roll = $urandom_range(99);
			if (roll < 8) begin
				send_report(1'b0, 1'($urandom_range(1)), $urandom());
			end else begin
				if (roll < 12) begin
					send_report(1'b1, 1'($urandom_range(1)), $urandom());
				end else begin
					roll = $urandom_range(99);
					if (dense) begin
						gap = (roll < 99) ? $urandom_range(0, span) : $urandom_range(0, 2 * win);
					end else if (roll < 75) begin
						gap = $urandom_range(0, span);
					end else if (roll < 95) begin
						gap = $urandom_range(0, win + win / 2 + 1);
					end else begin
						gap = $urandom_range(0, 2 * win + cool + 1);
					end
					now = now + gap;
					send_report(1'b1, 1'($urandom_range(1)), now);
				end
			end
			sent++;
			total_hits++;
		end
	endtask

	initial begin : stimulus
		int unsigned win;
		int unsigned thr;
		int unsigned cool;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Ignored reports at both timestamp extremes.
		send_report(1'b0, 1'b0, 32'h0000_0000);
		send_report(1'b0, 1'b1, 32'hFFFF_FFFF);
		// Class 0 reaches the threshold across the timestamp wrap; no cooldown before a first alarm.
		send_report(1'b1, 1'b0, 32'hFFFF_F000);
		send_report(1'b1, 1'b0, 32'hFFFF_F800);
		send_report(1'b1, 1'b0, 32'h0000_0100);
		// Class 1 collects three hits at the same tick.
		repeat (3) send_report(1'b1, 1'b1, 32'hFFFF_FFFF);
		// Class 0 inside its cooldown: hits count but stay silent.
		send_report(1'b1, 1'b0, 32'h0000_0200);
		send_report(1'b1, 1'b0, 32'h0000_0300);
		send_report(1'b1, 1'b0, 32'h0000_0400);
		// An age equal to the window keeps a hit; one tick more retires it.
		send_report(1'b1, 1'b0, 32'd6024);
		send_report(1'b1, 1'b0, 32'd6025);
		// Cooldown edge: one tick short stays silent, the exact cooldown fires.
		send_report(1'b1, 1'b0, 32'd15250);
		send_report(1'b1, 1'b0, 32'd15254);
		send_report(1'b1, 1'b0, 32'd15255);
		send_report(1'b1, 1'b0, 32'd15256);
		// An ignored report between hits changes nothing.
		send_report(1'b0, 1'b0, 32'd15300);

		for (int p = 0; p < PHASE_COUNT; p++) begin
			case (p)
				0: begin
					win = 1; thr = 1; cool = 0;
				end
				1: begin
					win = 20'hFFFFF; thr = 64; cool = 20'hFFFFF;
				end
				2: begin
					win = 3000; thr = 0; cool = 500;
				end
				3: begin
					win = 20'hFFFFF; thr = 100; cool = 0;
				end
				4: begin
					win  = $urandom_range(1, 20'hFFFFF);
					thr  = 127;
					cool = $urandom_range(0, 20'hFFFFF);
				end
				default: begin
					win  = $urandom_range(1, 20000);
					thr  = $urandom_range(1, 8);
					cool = $urandom_range(0, 40000);
				end
			endcase
			settle();
			load_settings(win, thr, cool, p >= 4);
			run_phase(win, thr, cool, p == 1 || p == 3);
		end

		settle();
		repeat (20) @(posedge clk);
		if (board.failures == 0 && board.pending() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

	// Result side: check every transfer and stall at random, with one long hold-off.
	initial begin : result_sink
		forever begin
			@(posedge clk);
			if (m_tvalid && m_tready) begin
				board.check_result(m_tdata, m_tuser);
				results_seen++;
			end
			if (!held_off && results_seen >= HOLD_AT) begin
				// The block fills up and has to hold back the report stream.
				held_off = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				m_tready <= ($urandom_range(99) >= sink_idle_pct);
			end
		end
	end

	initial begin : watchdog
		int unsigned cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAILURE");
		$finish;
	end

endmodule
